>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, held off while reset is active.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks an implication that must hold on every rising clock edge out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/mdd_pkg.sv
// Package with the types, codes and limits of the response deframer.
package mdd_pkg;

    // Largest frame that the downstream store can hold, in bytes.
    localparam int MAX_FRAME = 256;

    // Width used for limit compares, wide enough for 12 plus a byte and for MAX_FRAME.
    localparam int CMP_W = 10;
    localparam logic [CMP_W-1:0] CNT_LIMIT = CMP_W'(MAX_FRAME - 5);
    localparam logic [CMP_W-1:0] LEN_LIMIT = CMP_W'(MAX_FRAME - 12);

    // Protocol bytes.
    localparam logic [7:0] DLT_START = 8'h68;
    localparam logic [7:0] DLT_END   = 8'h16;

    // Frame positions where decisions are taken.
    localparam logic [8:0] MB_FUNC_IDX  = 9'd1;
    localparam logic [8:0] MB_COUNT_IDX = 9'd2;
    localparam logic [8:0] MB_LAST_HDR  = 9'd7;
    localparam logic [8:0] DL_START_IDX = 9'd7;
    localparam logic [8:0] DL_LEN_IDX   = 9'd9;
    localparam logic [7:0] MB_MIN_COUNT = 8'd3;
    localparam logic [8:0] DL_TAIL_XTRA = 9'd2;

    // Phase codes of the deframer state machine.
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_MB_HEAD = 3'd1;
    localparam logic [2:0] PH_MB_TAIL = 3'd2;
    localparam logic [2:0] PH_DL_HEAD = 3'd3;
    localparam logic [2:0] PH_DL_TAIL = 3'd4;

    // Frame kind codes.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_MB   = 2'd1;
    localparam logic [1:0] KIND_DLT  = 2'd2;

    // Event codes.
    localparam logic [2:0] EV_DISCARD = 3'd0;
    localparam logic [2:0] EV_ACCEPT  = 3'd1;
    localparam logic [2:0] EV_DONE    = 3'd2;
    localparam logic [2:0] EV_REJECT  = 3'd3;
    localparam logic [2:0] EV_LINE    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_ADDR  = 2'd0;
    localparam logic [1:0] REG_WRITE = 2'd1;
    localparam logic [1:0] REG_READ  = 2'd2;

    // Configuration register reset values.
    localparam logic [7:0] ADDR_RST  = 8'd255;
    localparam logic [7:0] WRITE_RST = 8'd6;
    localparam logic [7:0] READ_RST  = 8'd3;

    typedef struct packed {
        logic [2:0] phase;
        logic [8:0] byte_count;
        logic [8:0] bytes_remaining;
        logic [7:0] function_byte;
        logic [7:0] count_byte;
    } t_state;

    typedef struct packed {
        logic [7:0] expected_address;
        logic [7:0] write_function_code;
        logic [7:0] read_function_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [8:0] byte_index;
        logic [1:0] frame_kind;
        logic [2:0] event_res;
        logic       last;
    } t_res;

endpackage

>>> rtl/mdd_ifs.sv
// Channel interfaces of the deframer: received bytes, results and configuration writes.
interface mdd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       line_error;

    modport source(output valid, rx_byte, line_error, input ready);
    modport sink(input valid, rx_byte, line_error, output ready);
endinterface

interface mdd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic [1:0] frame_kind;
    logic [2:0] event_res;
    logic       last;

    modport source(output valid, data_byte, byte_index, frame_kind, event_res, last,
                   input ready);
    modport sink(input valid, data_byte, byte_index, frame_kind, event_res, last,
                 output ready);
endinterface

interface mdd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/modbus_dlt645_response_deframer.sv
// Top level of the Modbus RTU / DLT645 response deframer.
// Takes one received byte per clock cycle unless stalled and returns one result per byte,
// registered in an output register. The whole per-byte decision is a single pass of
// compare-and-count logic between the frame state registers and that output register,
// so a byte is taken in every cycle in which the output register is empty or its
// result is being taken at the same edge. Configuration writes are always taken.
module modbus_dlt645_response_deframer import mdd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mdd_cfg_if.sink    i_cfg,
    mdd_rx_if.sink     i_rx,
    mdd_res_if.source  o_res
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_res   r_res;
    t_res   n_res;
    logic   r_res_valid;
    logic   rx_take;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_address    <= ADDR_RST;
            r_cfg.write_function_code <= WRITE_RST;
            r_cfg.read_function_code  <= READ_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ADDR:  r_cfg.expected_address    <= i_cfg.data;
                REG_WRITE: r_cfg.write_function_code <= i_cfg.data;
                REG_READ:  r_cfg.read_function_code  <= i_cfg.data;
                default:   r_cfg                     <= r_cfg;
            endcase
        end
    end

    // Input is taken whenever the output register is empty or frees up in the same cycle.
    assign i_rx.ready = !r_res_valid || o_res.ready;
    assign rx_take    = i_rx.valid && i_rx.ready;

    mdd_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_byte  (i_rx.rx_byte),
        .i_err   (i_rx.line_error),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // Frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (rx_take) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (rx_take) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid      = r_res_valid;
    assign o_res.data_byte  = r_res.data_byte;
    assign o_res.byte_index = r_res.byte_index;
    assign o_res.frame_kind = r_res.frame_kind;
    assign o_res.event_res  = r_res.event_res;
    assign o_res.last       = r_res.last;

endmodule

>>> rtl/mdd_step.sv
// Per-byte decision logic: next deframer state and the result for one received byte.
module mdd_step import mdd_pkg::*; (
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_byte,
    input  logic       i_err,
    output t_state     o_state,
    output t_res       o_res
);

    logic       in_frame;
    logic [8:0] idx;
    logic [8:0] count_inc;
    logic       cnt_bad;
    logic       len_bad;

    assign idx       = i_state.byte_count;
    assign count_inc = idx + 9'd1;
    assign in_frame  = (i_state.phase == PH_MB_HEAD) || (i_state.phase == PH_MB_TAIL) ||
                       (i_state.phase == PH_DL_HEAD) || (i_state.phase == PH_DL_TAIL);

    // Range checks on the Modbus byte count and the DLT645 length byte.
    assign cnt_bad = (i_state.count_byte < MB_MIN_COUNT) ||
                     ({{(CMP_W-8){1'b0}}, i_state.count_byte} > CNT_LIMIT);
    assign len_bad = {{(CMP_W-8){1'b0}}, i_byte} > LEN_LIMIT;

    always_comb begin
        o_state          = i_state;
        o_res.data_byte  = i_byte;
        o_res.byte_index = 9'd0;
        o_res.frame_kind = KIND_NONE;
        o_res.event_res  = EV_DISCARD;
        o_res.last       = 1'b0;

        if (!in_frame) begin
            // Hunting: look for the start of a DLT645 or a Modbus frame.
            o_state.phase           = PH_HUNT;
            o_state.byte_count      = 9'd0;
            o_state.bytes_remaining = 9'd0;
            if (i_err) begin
                o_res.event_res = EV_LINE;
            end else if (i_byte == DLT_START) begin
                o_res.frame_kind   = KIND_DLT;
                o_res.event_res    = EV_ACCEPT;
                o_state.phase      = PH_DL_HEAD;
                o_state.byte_count = 9'd1;
            end else if (i_byte == i_cfg.expected_address) begin
                o_res.frame_kind   = KIND_MB;
                o_res.event_res    = EV_ACCEPT;
                o_state.phase      = PH_MB_HEAD;
                o_state.byte_count = 9'd1;
            end
        end else begin
            o_res.byte_index = idx;
            o_res.frame_kind = ((i_state.phase == PH_MB_HEAD) ||
                                (i_state.phase == PH_MB_TAIL)) ? KIND_MB : KIND_DLT;
            o_res.event_res  = EV_ACCEPT;
            if (i_err) begin
                // A line error aborts the frame.
                o_res.event_res         = EV_LINE;
                o_res.last              = 1'b1;
                o_state.phase           = PH_HUNT;
                o_state.byte_count      = 9'd0;
                o_state.bytes_remaining = 9'd0;
            end else begin
                o_state.byte_count = count_inc;
                unique case (i_state.phase)
                    PH_MB_HEAD: begin
                        if (idx == MB_FUNC_IDX) begin
                            o_state.function_byte = i_byte;
                        end
                        if (idx == MB_COUNT_IDX) begin
                            o_state.count_byte = i_byte;
                        end
                        // The header decision falls on byte 7.
                        if (idx >= MB_LAST_HDR) begin
                            o_res.last              = 1'b1;
                            o_state.phase           = PH_HUNT;
                            o_state.byte_count      = 9'd0;
                            o_state.bytes_remaining = 9'd0;
                            if (i_state.function_byte == i_cfg.write_function_code) begin
                                o_res.event_res = EV_DONE;
                            end else if (i_state.function_byte ==
                                         i_cfg.read_function_code) begin
                                if (cnt_bad) begin
                                    o_res.event_res = EV_REJECT;
                                end else if (i_state.count_byte == MB_MIN_COUNT) begin
                                    o_res.event_res = EV_DONE;
                                end else begin
                                    o_res.last              = 1'b0;
                                    o_state.phase           = PH_MB_TAIL;
                                    o_state.byte_count      = count_inc;
                                    o_state.bytes_remaining =
                                        {1'b0, i_state.count_byte} - {1'b0, MB_MIN_COUNT};
                                end
                            end else begin
                                o_res.event_res = EV_REJECT;
                            end
                        end
                    end
                    PH_DL_HEAD: begin
                        if (idx == DL_START_IDX) begin
                            o_state.function_byte = i_byte;
                        end
                        // The length byte decides whether the frame fits.
                        if (idx >= DL_LEN_IDX) begin
                            o_state.count_byte = i_byte;
                            if ((i_state.function_byte != DLT_START) || len_bad) begin
                                o_res.event_res         = EV_REJECT;
                                o_res.last              = 1'b1;
                                o_state.phase           = PH_HUNT;
                                o_state.byte_count      = 9'd0;
                                o_state.bytes_remaining = 9'd0;
                            end else begin
                                o_state.phase           = PH_DL_TAIL;
                                o_state.bytes_remaining = {1'b0, i_byte} + DL_TAIL_XTRA;
                            end
                        end
                    end
                    PH_MB_TAIL, PH_DL_TAIL: begin
                        // Tail bytes count down; the last one ends the frame.
                        if (i_state.bytes_remaining <= 9'd1) begin
                            o_res.last              = 1'b1;
                            o_state.phase           = PH_HUNT;
                            o_state.byte_count      = 9'd0;
                            o_state.bytes_remaining = 9'd0;
                            if ((i_state.phase == PH_DL_TAIL) && (i_byte != DLT_END)) begin
                                o_res.event_res = EV_REJECT;
                            end else begin
                                o_res.event_res = EV_DONE;
                            end
                        end else begin
                            o_state.bytes_remaining = i_state.bytes_remaining - 9'd1;
                        end
                    end
                    default: begin
                        o_state.phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

endmodule

>>> rtl/mdd_chk.sv
// Port-level checker for the deframer and the bind that attaches it.
`include "assert_macros.svh"

module mdd_chk import mdd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [8:0] i_byte_index,
    input logic [1:0] i_frame_kind,
    input logic [2:0] i_event_res,
    input logic       i_last
);

    logic stalled;
    logic is_discard;
    logic ends_frame;
    logic hunt_err;

    assign stalled    = i_valid && !i_ready;
    assign is_discard = i_valid && (i_event_res == EV_DISCARD);
    assign ends_frame = i_valid && ((i_event_res == EV_DONE) || (i_event_res == EV_REJECT));
    assign hunt_err   = i_valid && (i_event_res == EV_LINE) && (i_frame_kind == KIND_NONE);

    // A stalled result stays offered with the same event.
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, stalled |=> (i_valid && $stable(i_event_res)), "result changed while stalled")
    // Discarded bytes carry no frame position.
    `ASSERT_IMPL(a_discard_shape, i_clk, i_rst_n, is_discard, (i_byte_index == 9'd0) && (i_frame_kind == KIND_NONE) && !i_last, "discarded byte has frame fields")
    // Completion and rejection always close a frame of a known kind.
    `ASSERT_IMPL(a_end_last, i_clk, i_rst_n, ends_frame, i_last && (i_frame_kind != KIND_NONE), "frame end without last")
    // A line error while hunting closes nothing.
    `ASSERT_IMPL(a_hunt_err, i_clk, i_rst_n, hunt_err, !i_last && (i_byte_index == 9'd0), "line error while hunting marked last")

endmodule

bind modbus_dlt645_response_deframer mdd_chk u_mdd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_byte_index (o_res.byte_index),
    .i_frame_kind (o_res.frame_kind),
    .i_event_res  (o_res.event_res),
    .i_last       (o_res.last)
);

>>> tb/sv/tb.sv
// Self-checking testbench of the Modbus RTU / DLT645 response deframer.
`timescale 1ns / 100ps

module tb;
    import mdd_pkg::*;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_error;
    } t_rx_item;

    localparam int HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    mdd_cfg_if cfg_ch();
    mdd_rx_if  rx_ch();
    mdd_res_if res_ch();

    modbus_dlt645_response_deframer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    // Bytes waiting to be sent and results waiting to be seen.
    t_rx_item pending_bytes[$];
    t_res     expected_results[$];

    // Predicted frame state and register copy.
    logic [2:0] st_phase;
    logic [8:0] st_index;
    logic [8:0] st_left;
    logic [7:0] st_func;
    logic [7:0] st_count;
    t_cfg       cfg_model;

    // Idling controls and the long receiver hold-off.
    int gap_pct;
    int stall_pct;
    int hold_left;
    bit hold_request;
    int fail_count;

    // Register values that the stimulus currently builds frames for.
    logic [7:0] stim_addr;
    logic [7:0] stim_wr;
    logic [7:0] stim_rd;
    logic [7:0] frame_buf[$];
    int         phase_items;

    t_rx_item next_item;
    t_res     got_res;
    t_res     want_res;

    // Return the predicted frame state to hunting.
    function automatic void go_hunt();
        st_phase = PH_HUNT;
        st_index = '0;
        st_left  = '0;
    endfunction

    // Predict the result of one received byte and advance the frame state.
    function automatic t_res deframe_byte(input logic [7:0] b, input logic err);
        t_res       r;
        logic [2:0] ph;
        logic [8:0] idx;
        r.data_byte  = b;
        r.byte_index = '0;
        r.frame_kind = KIND_NONE;
        r.event_res  = EV_DISCARD;
        r.last       = 1'b0;
        ph = st_phase;
        if (ph > PH_DL_TAIL) ph = PH_HUNT;

        if (ph == PH_HUNT) begin
            if (err) begin
                r.event_res = EV_LINE;
                go_hunt();
            end else if (b == DLT_START) begin
                r.frame_kind = KIND_DLT;
                r.event_res  = EV_ACCEPT;
                st_phase     = PH_DL_HEAD;
                st_index     = 9'd1;
            end else if (b == cfg_model.expected_address) begin
                r.frame_kind = KIND_MB;
                r.event_res  = EV_ACCEPT;
                st_phase     = PH_MB_HEAD;
                st_index     = 9'd1;
            end else begin
                go_hunt();
            end
            return r;
        end

        idx = st_index;
        r.byte_index = idx;
        r.frame_kind = (ph == PH_MB_HEAD || ph == PH_MB_TAIL) ? KIND_MB : KIND_DLT;
        r.event_res  = EV_ACCEPT;
        if (err) begin
            r.event_res = EV_LINE;
            r.last      = 1'b1;
            go_hunt();
            return r;
        end

        case (ph)
            PH_MB_HEAD: begin
                if (idx == MB_FUNC_IDX) st_func = b;
                if (idx == MB_COUNT_IDX) st_count = b;
                st_index = st_index + 9'd1;
                if (idx >= MB_LAST_HDR) begin
                    r.last = 1'b1;
                    if (st_func == cfg_model.write_function_code) begin
                        r.event_res = EV_DONE;
                        go_hunt();
                    end else if (st_func == cfg_model.read_function_code) begin
                        if (st_count < MB_MIN_COUNT || int'(st_count) > MAX_FRAME - 5) begin
                            r.event_res = EV_REJECT;
                            go_hunt();
                        end else if (st_count == MB_MIN_COUNT) begin
                            r.event_res = EV_DONE;
                            go_hunt();
                        end else begin
                            r.last   = 1'b0;
                            st_phase = PH_MB_TAIL;
                            st_left  = {1'b0, st_count} - 9'(MB_MIN_COUNT);
                        end
                    end else begin
                        r.event_res = EV_REJECT;
                        go_hunt();
                    end
                end
            end
            PH_MB_TAIL: begin
                st_index = st_index + 9'd1;
                if (st_left <= 9'd1) begin
                    r.event_res = EV_DONE;
                    r.last      = 1'b1;
                    go_hunt();
                end else begin
                    st_left = st_left - 9'd1;
                end
            end
            PH_DL_HEAD: begin
                if (idx == DL_START_IDX) st_func = b;
                st_index = st_index + 9'd1;
                if (idx >= DL_LEN_IDX) begin
                    st_count = b;
                    if (st_func != DLT_START || int'(b) + 12 > MAX_FRAME) begin
                        r.event_res = EV_REJECT;
                        r.last      = 1'b1;
                        go_hunt();
                    end else begin
                        st_phase = PH_DL_TAIL;
                        st_left  = {1'b0, b} + DL_TAIL_XTRA;
                    end
                end
            end
            default: begin
                st_index = st_index + 9'd1;
                if (st_left <= 9'd1) begin
                    r.last      = 1'b1;
                    r.event_res = (b == DLT_END) ? EV_DONE : EV_REJECT;
                    go_hunt();
                end else begin
                    st_left = st_left - 9'd1;
                end
            end
        endcase
        return r;
    endfunction

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #4_000_000;
        $display("FAIL modbus_dlt645_response_deframer");
        $finish;
    end

    // Byte driver: predicts each accepted transaction and offers the next byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid      <= 1'b0;
            rx_ch.rx_byte    <= '0;
            rx_ch.line_error <= 1'b0;
            st_phase  = PH_HUNT;
            st_index  = '0;
            st_left   = '0;
            st_func   = '0;
            st_count  = '0;
            cfg_model = '{ADDR_RST, WRITE_RST, READ_RST};
        end else begin
            if (rx_ch.valid && rx_ch.ready)
                expected_results.push_back(deframe_byte(rx_ch.rx_byte, rx_ch.line_error));
            if (!rx_ch.valid || rx_ch.ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    next_item = pending_bytes.pop_front();
                    rx_ch.valid      <= 1'b1;
                    rx_ch.rx_byte    <= next_item.rx_byte;
                    rx_ch.line_error <= next_item.line_error;
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // Result monitor: compares each accepted transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got_res = '{res_ch.data_byte, res_ch.byte_index, res_ch.frame_kind,
                            res_ch.event_res, res_ch.last};
                if (expected_results.size() == 0) begin
                    $error("result with nothing predicted: data_byte %h", got_res.data_byte);
                    fail_count++;
                end else begin
                    want_res = expected_results.pop_front();
                    if (got_res.data_byte != want_res.data_byte) begin
                        $error("data_byte: expected %h, got %h",
                               want_res.data_byte, got_res.data_byte);
                        fail_count++;
                    end
                    if (got_res.byte_index != want_res.byte_index) begin
                        $error("byte_index: expected %0d, got %0d",
                               want_res.byte_index, got_res.byte_index);
                        fail_count++;
                    end
                    if (got_res.frame_kind != want_res.frame_kind) begin
                        $error("frame_kind: expected %0d, got %0d",
                               want_res.frame_kind, got_res.frame_kind);
                        fail_count++;
                    end
                    if (got_res.event_res != want_res.event_res) begin
                        $error("event_res: expected %0d, got %0d",
                               want_res.event_res, got_res.event_res);
                        fail_count++;
                    end
                    if (got_res.last != want_res.last) begin
                        $error("last: expected %0d, got %0d", want_res.last, got_res.last);
                        fail_count++;
                    end
                end
            end
            res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // Queue one byte for the driver.
    task automatic push_item(input logic [7:0] b, input logic err);
        pending_bytes.push_back('{b, err});
        phase_items++;
    endtask

    // Random byte that differs from the given one.
    function automatic logic [7:0] other_byte(input logic [7:0] avoid);
        logic [7:0] v;
        v = 8'($urandom);
        if (v == avoid) v = v ^ 8'h01;
        return v;
    endfunction

    // Send the built frame, now and then cut short by a line error.
    task automatic flush_frame();
        int err_at;
        err_at = -1;
        if ($urandom_range(11) == 0) err_at = $urandom_range(frame_buf.size() - 1);
        foreach (frame_buf[i]) begin
            push_item(frame_buf[i], i == err_at);
            if (i == err_at) break;
        end
        frame_buf.delete();
    endtask

    // Modbus response of eight bytes with the given function code.
    task automatic build_mb_write(input logic [7:0] func);
        frame_buf.push_back(stim_addr);
        frame_buf.push_back(func);
        repeat (6) frame_buf.push_back(8'($urandom));
        flush_frame();
    endtask

    // Modbus read response; a count in range brings its tail of data bytes.
    task automatic build_mb_read(input int count);
        frame_buf.push_back(stim_addr);
        frame_buf.push_back(stim_rd);
        frame_buf.push_back(8'(count));
        repeat (5) frame_buf.push_back(8'($urandom));
        if (count > 3 && count <= MAX_FRAME - 5)
            repeat (count - 3) frame_buf.push_back(8'($urandom));
        flush_frame();
    endtask

    // DLT645 frame with a chosen length, second start byte and end byte.
    task automatic build_dlt(input int len, input bit start_ok, input bit end_ok);
        frame_buf.push_back(DLT_START);
        repeat (6) frame_buf.push_back(8'($urandom));
        frame_buf.push_back(start_ok ? DLT_START : other_byte(DLT_START));
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(8'(len));
        if (start_ok && len + 12 <= MAX_FRAME) begin
            repeat (len + 1) frame_buf.push_back(8'($urandom));
            frame_buf.push_back(end_ok ? DLT_END : other_byte(DLT_END));
        end
        flush_frame();
    endtask

    // One random frame, mostly well formed, sometimes noise or a broken frame.
    task automatic gen_random_frame();
        int r;
        int x;
        r = $urandom_range(99);
        x = $urandom_range(199);
        if (r < 30) begin
            build_mb_write(($urandom_range(5) == 0) ? 8'($urandom) : stim_wr);
        end else if (r < 60) begin
            if (x < 3) build_mb_read($urandom_range(MAX_FRAME - 5, 200));
            else if (x < 8) build_mb_read($urandom_range(2));
            else if (x < 13) build_mb_read($urandom_range(255, MAX_FRAME - 4));
            else if (x < 40) build_mb_read(3);
            else build_mb_read($urandom_range(18, 4));
        end else if (r < 88) begin
            if (x < 3) build_dlt($urandom_range(MAX_FRAME - 12, 200), 1'b1, 1'b1);
            else if (x < 11) build_dlt($urandom_range(255, MAX_FRAME - 11), 1'b1, 1'b1);
            else build_dlt($urandom_range(12), $urandom_range(11) != 0,
                           $urandom_range(9) != 0);
        end else begin
            repeat ($urandom_range(3, 1)) push_item(8'($urandom), $urandom_range(3) == 0);
        end
    endtask

    // Wait until every byte is sent and every result has been seen.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || rx_ch.valid || expected_results.size() != 0
               || res_ch.valid);
    endtask

    // One register write transaction; the register copy follows at acceptance.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_ADDR:  cfg_model.expected_address    = val;
            REG_WRITE: cfg_model.write_function_code = val;
            REG_READ:  cfg_model.read_function_code  = val;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    // Reprogram the idle block, set the idling mix and queue random frames.
    task automatic run_phase(input logic [7:0] addr, input logic [7:0] wr,
                             input logic [7:0] rd, input int gap, input int stall,
                             input int items);
        wait_drained();
        write_reg(REG_ADDR, addr);
        write_reg(REG_WRITE, wr);
        write_reg(REG_READ, rd);
        @(negedge i_clk);
        stim_addr   = addr;
        stim_wr     = wr;
        stim_rd     = rd;
        gap_pct     = gap;
        stall_pct   = stall;
        phase_items = 0;
        while (phase_items < items) gen_random_frame();
    endtask

    // Stimulus sequence.
    initial begin
        i_rst_n          = 1'b0;
        rx_ch.valid      = 1'b0;
        rx_ch.rx_byte    = '0;
        rx_ch.line_error = 1'b0;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_ADDR;
        cfg_ch.data      = '0;
        gap_pct          = 0;
        stall_pct        = 0;
        hold_request     = 1'b0;
        fail_count       = 0;
        phase_items      = 0;
        stim_addr        = ADDR_RST;
        stim_wr          = WRITE_RST;
        stim_rd          = READ_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes under the reset register values.
        @(negedge i_clk);
        push_item(8'h00, 1'b1);          // line error while hunting
        push_item(8'h00, 1'b0);          // discarded byte
        frame_buf = '{ADDR_RST, WRITE_RST, 8'h00, 8'h01, 8'h12, 8'h34, 8'hAB, 8'hCD};
        foreach (frame_buf[i]) push_item(frame_buf[i], 1'b0);
        frame_buf = '{DLT_START, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, DLT_START,
                      8'h81, 8'h00, 8'hFF, DLT_END};
        foreach (frame_buf[i]) push_item(frame_buf[i], 1'b0);
        frame_buf.delete();
        push_item(ADDR_RST, 1'b0);       // line error inside a Modbus frame
        push_item(READ_RST, 1'b0);
        push_item(8'hFF, 1'b1);

        // Random phases over several register settings and idling mixes.
        run_phase(8'h11, 8'h06, 8'h03, 0, 0, 80);
        build_mb_read(MAX_FRAME - 5);
        build_mb_read(3);
        build_dlt(MAX_FRAME - 12, 1'b1, 1'b1);
        run_phase(DLT_START, 8'h10, 8'h04, 74, 0, 80);
        run_phase(8'h00, 8'hFF, 8'h00, 0, 74, 80);
        run_phase(8'hFF, 8'h00, 8'hFF, 23, 23, 80);
        run_phase(8'($urandom), 8'($urandom), 8'($urandom), 23, 23, 70);
        run_phase(8'h01, 8'h05, 8'h05, 0, 0, 60);

        // Receiver holds off while the sender keeps offering bytes.
        run_phase(8'h2A, 8'h06, 8'h03, 0, 0, 60);
        hold_request = 1'b1;
        do @(negedge i_clk);
        while (hold_left == 0);
        hold_request = 1'b0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASS modbus_dlt645_response_deframer");
        end else begin
            $display("FAIL modbus_dlt645_response_deframer");
        end
        $finish;
    end

endmodule

>>> modbus_dlt645_response_deframer.f
+incdir+rtl
rtl/mdd_pkg.sv
rtl/mdd_ifs.sv
rtl/mdd_step.sv
rtl/modbus_dlt645_response_deframer.sv
rtl/mdd_chk.sv
tb/sv/tb.sv
